FILE: src/jcqn_pkg.sv
// Shared types and constants for the JSON5 comment and quote normalizer.
package jcqn_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    M_NORMAL = 4'd0,
    M_SLASH  = 4'd1,
    M_DSTR   = 4'd2,
    M_DESC   = 4'd3,
    M_SSTR   = 4'd4,
    M_SESC   = 4'd5,
    M_LINE   = 4'd6,
    M_BLOCK  = 4'd7,
    M_BSTAR  = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_STRING = 2'd1,
    FAULT_BLOCK  = 2'd2
  } fault_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       saw_comments;
    logic [1:0] fault_code;
  } out_word_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0][7:0] res_byte;
    mode_e           mode_nxt;
    logic            seen_nxt;
    logic            saw;
    fault_e          fault;
  } lex_t;

endpackage

FILE: src/jcqn_lexer.sv
// Lexer step: results and next mode for one input word.
module jcqn_lexer (
  input  jcqn_pkg::mode_e    mode_i,
  input  logic               seen_i,
  input  jcqn_pkg::in_word_t word_i,
  output jcqn_pkg::lex_t     res_o
);
  import jcqn_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [7:0] b;
    mode_e      mode;
  } step_t;

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic step_t normal_fn(input logic [7:0] c);
    step_t s;
    s.emit = 1'b1;
    s.b    = c;
    s.mode = M_NORMAL;
    if (c == CH_DQUOTE) begin
      s.mode = M_DSTR;
    end else if (c == CH_SQUOTE) begin
      s.b    = CH_DQUOTE;
      s.mode = M_SSTR;
    end else if (c == CH_SLASH) begin
      s.emit = 1'b0;
      s.mode = M_SLASH;
    end
    return s;
  endfunction

  function automatic step_t block_fn(input logic [7:0] c);
    step_t s;
    s.emit = 1'b1;
    s.b    = is_nl(c) ? c : CH_SPACE;
    s.mode = M_BLOCK;
    if (c == CH_STAR) begin
      s.emit = 1'b0;
      s.mode = M_BSTAR;
    end
    return s;
  endfunction

  logic [7:0]      c;
  logic [1:0][7:0] ob;
  logic [1:0]      n;
  mode_e           mode_d;
  logic            seen_d;
  fault_e          fault;
  step_t           st;

  assign c = word_i.in_byte;

  always_comb begin
    ob     = '0;
    n      = 2'd0;
    mode_d = mode_i;
    seen_d = seen_i;
    fault  = FAULT_NONE;
    st     = normal_fn(c);
    case (mode_i)
      M_SLASH: begin
        if (c == CH_SLASH || c == CH_STAR) begin
          ob[0]  = CH_SPACE;
          ob[1]  = CH_SPACE;
          n      = 2'd2;
          seen_d = 1'b1;
          mode_d = (c == CH_SLASH) ? M_LINE : M_BLOCK;
        end else begin
          ob[0]  = CH_SLASH;
          n      = 2'd1;
          mode_d = st.mode;
          if (st.emit) begin
            ob[1] = st.b;
            n     = 2'd2;
          end
        end
      end
      M_DSTR: begin
        ob[0] = c;
        n     = 2'd1;
        if (c == CH_BSLASH) begin
          mode_d = M_DESC;
        end else if (c == CH_DQUOTE) begin
          mode_d = M_NORMAL;
        end
      end
      M_DESC: begin
        ob[0]  = c;
        n      = 2'd1;
        mode_d = M_DSTR;
      end
      M_SSTR: begin
        if (c == CH_BSLASH) begin
          mode_d = M_SESC;
        end else if (c == CH_DQUOTE) begin
          ob[0] = CH_BSLASH;
          ob[1] = CH_DQUOTE;
          n     = 2'd2;
        end else if (c == CH_SQUOTE) begin
          ob[0]  = CH_DQUOTE;
          n      = 2'd1;
          mode_d = M_NORMAL;
        end else begin
          ob[0] = c;
          n     = 2'd1;
        end
      end
      M_SESC: begin
        if (c == CH_SQUOTE) begin
          ob[0] = CH_SQUOTE;
          n     = 2'd1;
        end else begin
          ob[0] = CH_BSLASH;
          ob[1] = c;
          n     = 2'd2;
        end
        mode_d = M_SSTR;
      end
      M_LINE: begin
        if (is_nl(c)) begin
          ob[0]  = c;
          mode_d = M_NORMAL;
        end else begin
          ob[0] = CH_SPACE;
        end
        n = 2'd1;
      end
      M_BLOCK: begin
        st     = block_fn(c);
        ob[0]  = st.b;
        n      = {1'b0, st.emit};
        mode_d = st.mode;
      end
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          ob[0]  = CH_SPACE;
          ob[1]  = CH_SPACE;
          n      = 2'd2;
          mode_d = M_NORMAL;
        end else begin
          st     = block_fn(c);
          ob[0]  = CH_SPACE;
          ob[1]  = st.b;
          n      = st.emit ? 2'd2 : 2'd1;
          mode_d = st.mode;
        end
      end
      default: begin
        ob[0]  = st.b;
        n      = {1'b0, st.emit};
        mode_d = st.mode;
      end
    endcase

    // end of document: flush pending lookahead, at most two words kept
    if (word_i.in_end) begin
      case (mode_d)
        M_SLASH: begin
          if (n != 2'd2) begin
            ob[n[0]] = CH_SLASH;
            n        = n + 2'd1;
          end
        end
        M_DSTR, M_DESC, M_SSTR: begin
          fault = FAULT_STRING;
        end
        M_SESC: begin
          if (n != 2'd2) begin
            ob[n[0]] = CH_BSLASH;
            n        = n + 2'd1;
          end
          fault = FAULT_STRING;
        end
        M_BLOCK: begin
          fault = FAULT_BLOCK;
        end
        M_BSTAR: begin
          if (n != 2'd2) begin
            ob[n[0]] = CH_SPACE;
            n        = n + 2'd1;
          end
          fault = FAULT_BLOCK;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.cnt         = n;
    res_o.res_byte[0] = ob[0];
    res_o.res_byte[1] = ob[1];
    res_o.saw         = seen_d;
    res_o.fault       = fault;
    res_o.mode_nxt    = word_i.in_end ? M_NORMAL : mode_d;
    res_o.seen_nxt    = word_i.in_end ? 1'b0 : seen_d;
  end

endmodule

FILE: src/jcqn_out_stage.sv
// Output register stage: holds one result word until the receiver takes it.
module jcqn_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  jcqn_pkg::out_word_t word_i,
  input  logic                ready_i,
  output logic                free_o,
  output logic                valid_o,
  output jcqn_pkg::out_word_t word_o
);
  import jcqn_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: src/json5_comment_quote_normalizer_top.sv
// JSON5 comment and quote normalizer, top level.
//
// Input channel (in_valid_i / in_ready_o / in_word_i) takes one text byte
// per word; in_end marks the last byte of a document. Output channel
// (out_valid_o / out_ready_i / out_word_o) gives zero, one or two words per
// input word; out_end marks the last word of a document, which also carries
// saw_comments and fault_code.
// Latency: the result words of an input word pass from the input register
// through the combinational lexer into the output register.
// Throughput: one input word per cycle while each causes at most one result
// and the receiver takes every word; a word with two results holds the input
// register longer, since the single output register takes one result word per cycle.
// Reset clears the input and output valid flags and returns the lexer to
// plain text with no comment seen; nothing is pending afterwards.
// When the receiver stalls, the output register holds its word; once the held
// input word has results, in_ready_o drops until the output frees up.
// Each document end also returns the lexer to its reset state.
module json5_comment_quote_normalizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jcqn_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jcqn_pkg::out_word_t out_word_o
);
  import jcqn_pkg::*;

  logic      in_vld_q;
  in_word_t  in_q;
  mode_e     mode_q;
  logic      seen_q;
  logic      idx_q;
  lex_t      res;
  logic      out_free;
  logic      last_sel;
  logic      push;
  logic      retire;
  logic      fin;
  out_word_t out_d;

  jcqn_lexer u_lexer (
    .mode_i (mode_q),
    .seen_i (seen_q),
    .word_i (in_q),
    .res_o  (res)
  );

  assign last_sel   = idx_q || (res.cnt == 2'd1);
  assign push       = in_vld_q && out_free && (res.cnt != 2'd0);
  assign retire     = in_vld_q && ((res.cnt == 2'd0) || (out_free && last_sel));
  assign in_ready_o = !in_vld_q || retire;
  assign fin        = in_q.in_end && last_sel;

  always_comb begin
    out_d.out_byte     = idx_q ? res.res_byte[1] : res.res_byte[0];
    out_d.out_end      = fin;
    out_d.saw_comments = fin ? res.saw : 1'b0;
    out_d.fault_code   = fin ? res.fault : FAULT_NONE;
  end

  jcqn_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (push),
    .word_i  (out_d),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= M_NORMAL;
      seen_q   <= 1'b0;
      idx_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (retire) begin
        mode_q <= res.mode_nxt;
        seen_q <= res.seen_nxt;
        idx_q  <= 1'b0;
      end else if (push) begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  // second result slot is only used while a two-result word is held
  a_idx_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (in_vld_q && res.cnt == 2'd2))
    else $error("result index set without a two-result word");

  a_tail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.out_end) |->
      (!out_word_o.saw_comments && out_word_o.fault_code == FAULT_NONE))
    else $error("status bits set on a word that is not the document end");

  a_doc_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && in_q.in_end) |=> (mode_q == M_NORMAL && !seen_q))
    else $error("lexer state not cleared after document end");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !retire) |=> (in_vld_q && $stable(in_q)))
    else $error("held input word lost before its results were sent");

endmodule

FILE: bench/json5_comment_quote_normalizer_top_test.sv
// Self-checking testbench for the JSON5 comment and quote normalizer top level.
`timescale 1ns / 100ps

module json5_comment_quote_normalizer_top_test;
  import jcqn_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  json5_comment_quote_normalizer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer prediction state
  mode_e      lex_mode  = M_NORMAL;
  logic       lex_seen  = 1'b0;
  logic [7:0] emit_buf [2];
  int         emit_cnt;
  out_word_t  expected_words [$];

  logic [7:0] doc_bytes [$];
  logic       tx_gaps    = 1'b1;
  int         burst_left = 0;
  int         words_sent = 0;
  int         docs_sent  = 0;
  int         words_checked = 0;
  int         ends_clean = 0, ends_string = 0, ends_block = 0, ends_commented = 0;
  int         mismatch_count = 0;
  out_word_t  want_word;

  rx_style_e    rx_style = RX_OPEN;
  logic [15:0]  rx_tick  = '0;

  function automatic void emit_byte(input logic [7:0] b);
    if (emit_cnt < 2) begin
      emit_buf[emit_cnt] = b;
      emit_cnt++;
    end
  endfunction

  function automatic void lex_plain(input logic [7:0] c);
    lex_mode = M_NORMAL;
    if (c == CH_DQUOTE) begin
      emit_byte(c);
      lex_mode = M_DSTR;
    end else if (c == CH_SQUOTE) begin
      emit_byte(CH_DQUOTE);
      lex_mode = M_SSTR;
    end else if (c == CH_SLASH) begin
      lex_mode = M_SLASH;
    end else begin
      emit_byte(c);
    end
  endfunction

  function automatic void lex_block(input logic [7:0] c);
    lex_mode = M_BLOCK;
    if (c == CH_STAR) begin
      lex_mode = M_BSTAR;
    end else begin
      emit_byte((c == CH_LF || c == CH_CR) ? c : CH_SPACE);
    end
  endfunction

  function automatic void predict_word(input logic [7:0] c, input logic last);
    fault_e    flt;
    out_word_t w;
    flt = FAULT_NONE;
    emit_cnt = 0;
    case (lex_mode)
      M_NORMAL: lex_plain(c);
      M_SLASH: begin
        if (c == CH_SLASH || c == CH_STAR) begin
          emit_byte(CH_SPACE);
          emit_byte(CH_SPACE);
          lex_seen = 1'b1;
          lex_mode = (c == CH_SLASH) ? M_LINE : M_BLOCK;
        end else begin
          emit_byte(CH_SLASH);
          lex_plain(c);
        end
      end
      M_DSTR: begin
        emit_byte(c);
        if (c == CH_BSLASH) lex_mode = M_DESC;
        else if (c == CH_DQUOTE) lex_mode = M_NORMAL;
      end
      M_DESC: begin
        emit_byte(c);
        lex_mode = M_DSTR;
      end
      M_SSTR: begin
        if (c == CH_BSLASH) begin
          lex_mode = M_SESC;
        end else if (c == CH_DQUOTE) begin
          emit_byte(CH_BSLASH);
          emit_byte(CH_DQUOTE);
        end else if (c == CH_SQUOTE) begin
          emit_byte(CH_DQUOTE);
          lex_mode = M_NORMAL;
        end else begin
          emit_byte(c);
        end
      end
      M_SESC: begin
        if (c == CH_SQUOTE) begin
          emit_byte(CH_SQUOTE);
        end else begin
          emit_byte(CH_BSLASH);
          emit_byte(c);
        end
        lex_mode = M_SSTR;
      end
      M_LINE: begin
        if (c == CH_LF || c == CH_CR) begin
          emit_byte(c);
          lex_mode = M_NORMAL;
        end else begin
          emit_byte(CH_SPACE);
        end
      end
      M_BLOCK: lex_block(c);
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          emit_byte(CH_SPACE);
          emit_byte(CH_SPACE);
          lex_mode = M_NORMAL;
        end else begin
          emit_byte(CH_SPACE);
          lex_block(c);
        end
      end
      default: lex_plain(c);
    endcase
    if (last) begin
      case (lex_mode)
        M_SLASH: emit_byte(CH_SLASH);
        M_DSTR, M_DESC, M_SSTR: flt = FAULT_STRING;
        M_SESC: begin
          emit_byte(CH_BSLASH);
          flt = FAULT_STRING;
        end
        M_BLOCK: flt = FAULT_BLOCK;
        M_BSTAR: begin
          emit_byte(CH_SPACE);
          flt = FAULT_BLOCK;
        end
        default: ;
      endcase
    end
    for (int k = 0; k < emit_cnt; k++) begin
      w.out_byte     = emit_buf[k];
      w.out_end      = last && (k == emit_cnt - 1);
      w.saw_comments = w.out_end & lex_seen;
      w.fault_code   = w.out_end ? flt : FAULT_NONE;
      expected_words.push_back(w);
    end
    if (last) begin
      lex_mode = M_NORMAL;
      lex_seen = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input out_word_t got, input out_word_t want);
    if (mismatch_count < 20) begin
      $display("%0t mismatch %s: got %02h/%0b/%0b/%0d want %02h/%0b/%0b/%0d", $realtime,
               what, got.out_byte, got.out_end, got.saw_comments, got.fault_code,
               want.out_byte, want.out_end, want.saw_comments, want.fault_code);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (out_word_o.out_end) begin
        if (out_word_o.fault_code == FAULT_STRING) ends_string++;
        else if (out_word_o.fault_code == FAULT_BLOCK) ends_block++;
        else ends_clean++;
        if (out_word_o.saw_comments) ends_commented++;
      end
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word_o, '0);
      end else begin
        want_word = expected_words.pop_front();
        if (out_word_o.out_byte != want_word.out_byte)
          report_mismatch("out_byte", out_word_o, want_word);
        if (out_word_o.out_end != want_word.out_end)
          report_mismatch("out_end", out_word_o, want_word);
        if (out_word_o.saw_comments != want_word.saw_comments)
          report_mismatch("saw_comments", out_word_o, want_word);
        if (out_word_o.fault_code != want_word.fault_code)
          report_mismatch("fault_code", out_word_o, want_word);
      end
    end
  end

  // receiver back-pressure, style changes when the low byte of rx_tick wraps
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[7:0] == 8'hFF) rx_style <= rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready_i <= (rx_tick[2:0] < 3'd5);
      default:     out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    if (tx_gaps && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{in_byte: b, in_end: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(b, last);
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++) begin
      send_word(doc_bytes[i], i == doc_bytes.size() - 1);
    end
    docs_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_byte(input int mark_pct);
    logic [7:0] marks [8];
    marks = '{CH_DQUOTE, CH_SQUOTE, CH_SLASH, CH_STAR, CH_BSLASH, CH_LF, CH_CR, CH_SPACE};
    if ($urandom_range(0, 99) < mark_pct) return marks[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] body_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
    logic [7:0] b;
    b = text_byte(20);
    if (b == stop_a || b == stop_b) b = 8'h5F;
    return b;
  endfunction

  task automatic add_token();
    int   len;
    logic broken;
    len    = $urandom_range(0, 6);
    broken = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 7))
      0, 1: begin
        repeat (len + 1) doc_bytes.push_back(body_byte(CH_DQUOTE, CH_SQUOTE) == CH_SLASH ?
                                              8'h2E : body_byte(CH_DQUOTE, CH_SQUOTE));
      end
      2: begin
        doc_bytes.push_back(CH_DQUOTE);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            doc_bytes.push_back(CH_BSLASH);
            doc_bytes.push_back(text_byte(40));
          end else begin
            doc_bytes.push_back(body_byte(CH_DQUOTE, CH_BSLASH));
          end
        end
        if (!broken) doc_bytes.push_back(CH_DQUOTE);
      end
      3: begin
        doc_bytes.push_back(CH_SQUOTE);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            doc_bytes.push_back(CH_BSLASH);
            doc_bytes.push_back($urandom_range(0, 1) ? CH_SQUOTE : text_byte(40));
          end else if ($urandom_range(0, 4) == 0) begin
            doc_bytes.push_back(CH_DQUOTE);
          end else begin
            doc_bytes.push_back(body_byte(CH_SQUOTE, CH_BSLASH));
          end
        end
        if (!broken) doc_bytes.push_back(CH_SQUOTE);
      end
      4: begin
        doc_bytes.push_back(CH_SLASH);
        doc_bytes.push_back(CH_SLASH);
        repeat (len) doc_bytes.push_back(body_byte(CH_LF, CH_CR));
        if (!broken) doc_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      5: begin
        doc_bytes.push_back(CH_SLASH);
        doc_bytes.push_back(CH_STAR);
        repeat (len) doc_bytes.push_back(body_byte(CH_SLASH, CH_SLASH));
        if (!broken) begin
          doc_bytes.push_back(CH_STAR);
          doc_bytes.push_back(CH_SLASH);
        end
      end
      6: repeat (len + 1) doc_bytes.push_back(text_byte(30));
      default: begin
        repeat (len + 1) doc_bytes.push_back(text_byte(100) & 8'h2F | 8'h00);
      end
    endcase
  endtask

  task automatic run_documents(input int word_budget, input int max_tokens);
    int start;
    start = words_sent;
    while (words_sent - start < word_budget) begin
      doc_bytes.delete();
      repeat ($urandom_range(1, max_tokens)) add_token();
      send_doc();
    end
  endtask

  task automatic test_directed_cases();
    // slash resolved by plain text, then slash pending at the end
    doc_bytes = '{CH_SLASH, 8'h61, CH_SLASH};
    send_doc();
    // line comment with its newline kept, top byte value
    doc_bytes = '{CH_SLASH, CH_SLASH, 8'h78, CH_LF, 8'hFF};
    send_doc();
    // block comment holding CR and a double star close
    doc_bytes = '{CH_SLASH, CH_STAR, CH_CR, CH_STAR, CH_STAR, CH_SLASH};
    send_doc();
    // single-quoted string: escaped quote, inner double quote, backslash pending at end
    doc_bytes = '{CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_BSLASH, 8'h71, CH_BSLASH};
    send_doc();
    // unterminated double-quoted string with an escape, zero byte
    doc_bytes = '{CH_DQUOTE, CH_BSLASH, CH_DQUOTE, 8'h00};
    send_doc();
    // star pending in an open block comment at the end
    doc_bytes = '{CH_SLASH, CH_STAR, CH_STAR};
    send_doc();
    doc_bytes = '{8'hC3};
    send_doc();
    wait_drained();
  endtask

  task automatic test_document_end_flush();
    repeat (60) begin
      doc_bytes.delete();
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(text_byte(75));
      send_doc();
    end
    wait_drained();
  endtask

  task automatic test_streaming();
    tx_gaps = 1'b0;
    run_documents(300, 6);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_documents();
    run_documents(550, 10);
    wait_drained();
    run_documents(550, 10);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_document_end_flush();
    test_streaming();
    test_random_documents();
    wait_drained();
    if (expected_words.size() != 0) begin
      report_mismatch("words never delivered", '0, expected_words[0]);
    end
    $display("sent %0d bytes in %0d documents, checked %0d output words",
             words_sent, docs_sent, words_checked);
    $display("document ends: %0d clean, %0d open string, %0d open block, %0d with comments",
             ends_clean, ends_string, ends_block, ends_commented);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
